// ===== design/rawsocket_frame_deframer_defines.svh =====
// assertion macros for the rawsocket deframer
// used by the top level only; expects clk and rst_n in scope
`ifndef RAWSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define RAWSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RDF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdf assertion failed");

// next-cycle implication, checked outside reset
`define RDF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdf assertion failed");

`endif

// ===== design/rdf_pkg.sv =====
// shared types and constants of the rawsocket deframer
// no dependencies
package rdf_pkg;

  // event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_HS_OK     = 3'd1;
  localparam logic [2:0] EV_DATA      = 3'd2;
  localparam logic [2:0] EV_BAD_MAGIC = 3'd3;
  localparam logic [2:0] EV_RESERVED  = 3'd4;
  localparam logic [2:0] EV_EMPTY     = 3'd5;

  // parser phases
  localparam logic [1:0] PH_HANDSHAKE = 2'd0;
  localparam logic [1:0] PH_PREFIX    = 2'd1;
  localparam logic [1:0] PH_PAYLOAD   = 2'd2;

  // handshake byte positions
  localparam logic [1:0] HS_MAGIC  = 2'd0;
  localparam logic [1:0] HS_FORMAT = 2'd1;
  localparam logic [1:0] HS_RSV0   = 2'd2;
  localparam logic [1:0] HS_RSV1   = 2'd3;

  // last byte position of the length prefix
  localparam logic [1:0] PREFIX_LAST = 2'd3;

  localparam logic [7:0] MAGIC_BYTE = 8'h7f;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic       frame_last;
    logic [3:0] max_len_exponent;
    logic [3:0] serializer_code;
  } rdf_result_t;

endpackage

// ===== design/rdf_in_stage.sv =====
// input register of the rawsocket deframer
// depends on nothing but its ports
module rdf_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       adv,
  output logic       hold_v,
  output logic [7:0] hold_byte
);

  logic       v_r, v_nxt;
  logic [7:0] byte_r;
  logic       take;

  assign in_ready = !v_r || adv;
  assign take     = in_valid && in_ready;
  assign v_nxt    = take ? 1'b1 : (adv ? 1'b0 : v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_rx_byte;
    end
  end

  assign hold_v    = v_r;
  assign hold_byte = byte_r;

endmodule

// ===== design/rdf_parser.sv =====
// handshake and frame parser state with its next-state logic
// depends on rdf_pkg
module rdf_parser
  import rdf_pkg::*;
#(
  parameter int LEN_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output rdf_result_t res
);

  logic [1:0]          phase_r, phase_nxt;
  logic [LEN_BITS-1:0] idx_r, idx_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic [3:0]          exp_r, exp_nxt;
  logic [3:0]          ser_r, ser_nxt;

  logic [LEN_BITS-1:0] idx_inc;
  logic [LEN_BITS-1:0] len_base;
  logic [LEN_BITS+7:0] len_wide;
  logic [LEN_BITS-1:0] len_shift;

  assign idx_inc   = idx_r + LEN_BITS'(1);
  // first prefix byte starts a fresh length
  assign len_base  = (idx_r == '0) ? '0 : len_r;
  assign len_wide  = {len_base, rx_byte};
  assign len_shift = len_wide[LEN_BITS-1:0];

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    exp_nxt   = exp_r;
    ser_nxt   = ser_r;
    res.event_res    = EV_NONE;
    res.payload_byte = 8'h00;
    res.frame_last   = 1'b0;
    case (phase_r)
      PH_PREFIX: begin
        len_nxt = len_shift;
        idx_nxt = idx_inc;
        if (idx_r[1:0] == PREFIX_LAST) begin
          idx_nxt = '0;
          if (len_shift == '0) begin
            res.event_res = EV_EMPTY;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res.event_res    = EV_DATA;
        res.payload_byte = rx_byte;
        idx_nxt          = idx_inc;
        if (idx_inc == len_r) begin
          res.frame_last = 1'b1;
          phase_nxt      = PH_PREFIX;
          idx_nxt        = '0;
        end
      end
      default: begin
        // handshake; unused phase code behaves the same
        phase_nxt = PH_HANDSHAKE;
        case (idx_r[1:0])
          HS_MAGIC: begin
            if (rx_byte != MAGIC_BYTE) begin
              res.event_res = EV_BAD_MAGIC;
            end else begin
              idx_nxt = idx_inc;
            end
          end
          HS_FORMAT: begin
            exp_nxt = rx_byte[7:4];
            ser_nxt = rx_byte[3:0];
            idx_nxt = idx_inc;
          end
          HS_RSV0: begin
            if (rx_byte != 8'h00) begin
              res.event_res = EV_RESERVED;
              idx_nxt       = '0;
            end else begin
              idx_nxt = idx_inc;
            end
          end
          default: begin
            idx_nxt = '0;
            if (rx_byte != 8'h00) begin
              res.event_res = EV_RESERVED;
            end else begin
              res.event_res = EV_HS_OK;
              phase_nxt     = PH_PREFIX;
              len_nxt       = '0;
            end
          end
        endcase
      end
    endcase
    res.max_len_exponent = exp_nxt;
    res.serializer_code  = ser_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HANDSHAKE;
      idx_r   <= '0;
      len_r   <= '0;
      exp_r   <= 4'h0;
      ser_r   <= 4'h0;
    end else if (step) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      exp_r   <= exp_nxt;
      ser_r   <= ser_nxt;
    end
  end

endmodule

// ===== design/rdf_out_stage.sv =====
// result register of the rawsocket deframer
// depends on rdf_pkg
module rdf_out_stage
  import rdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  rdf_result_t res,
  output logic        adv,
  output logic        out_valid,
  input  logic        out_ready,
  output rdf_result_t out_res
);

  logic        v_r, v_nxt;
  rdf_result_t res_r;

  assign adv   = !v_r || out_ready;
  assign v_nxt = load ? 1'b1 : (out_ready ? 1'b0 : v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = v_r;
  assign out_res   = res_r;

endmodule

// ===== design/rawsocket_frame_deframer.sv =====
// rawsocket_frame_deframer: receive-side deframer, one stream byte per transaction
// depends on rdf_pkg, rdf_in_stage, rdf_parser, rdf_out_stage and the defines header
//
// usage:
//   input channel  in_valid/in_ready carries in_rx_byte, one byte of the stream
//   result channel out_valid/out_ready carries one result per input byte:
//     out_event_res (none, handshake ok, payload byte, bad magic, reserved
//     nonzero, empty frame), out_payload_byte, out_frame_last and the peer's
//     max length exponent and serializer taken from the handshake
//   the stream starts with a four-byte handshake, then frames of a four-byte
//     big-endian length prefix followed by that many payload bytes
// timing:
//   a byte is registered on acceptance and parsed into the result register once
//     that register can take it; out_valid rises when the result is loaded
//   throughput is one byte per cycle while out_ready is high; parsing is combinational
// reset (rst_n low, synchronous): parser back to the first handshake byte,
//   length and peer fields cleared, both pipeline registers emptied
// stall: while out_ready is low the result register holds, the input register
//   keeps one more byte, and in_ready drops only when both are full
`include "rawsocket_frame_deframer_defines.svh"

module rawsocket_frame_deframer
  import rdf_pkg::*;
#(
  parameter int LEN_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_res,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_last,
  output logic [3:0] out_max_len_exponent,
  output logic [3:0] out_serializer_code
);

  // pipeline handshake between the two registers
  logic        adv;
  logic        hold_v;
  logic [7:0]  hold_byte;
  logic        step;
  rdf_result_t res;
  rdf_result_t out_res;

  // a parse step happens when a byte waits and the result register can take it
  assign step = hold_v && adv;

  rdf_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .adv       (adv),
    .hold_v    (hold_v),
    .hold_byte (hold_byte)
  );

  // handshake check, prefix assembly and payload counting
  rdf_parser #(
    .LEN_BITS(LEN_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .rx_byte(hold_byte),
    .res    (res)
  );

  rdf_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .res      (res),
    .adv      (adv),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_event_res        = out_res.event_res;
  assign out_payload_byte     = out_res.payload_byte;
  assign out_frame_last       = out_res.frame_last;
  assign out_max_len_exponent = out_res.max_len_exponent;
  assign out_serializer_code  = out_res.serializer_code;

  // last marker only on payload bytes
  `RDF_ASSERT_IMP(a_last_is_data, out_valid && out_frame_last, out_event_res == EV_DATA)
  // payload byte is zero outside payload results
  `RDF_ASSERT_IMP(a_data_zero, out_valid && (out_event_res != EV_DATA), out_payload_byte == 8'h00)
  // both registers full and receiver stalled: no new input transaction
  `RDF_ASSERT_IMP(a_full_blocks, hold_v && out_valid && !out_ready, !in_ready)
  // a stalled result stays in place
  `RDF_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_res))

endmodule

// ===== test/tb.sv =====
// testbench for rawsocket_frame_deframer: handshake checks, length prefixes and payload framing
// needs rdf_pkg and the deframer rtl; a scoreboard class predicts one result per accepted byte
// and checks every result transaction in order

class deframe_scoreboard;
  localparam int LEN_BITS = 32;
  localparam int unsigned PREFIX_BYTES = 4;
  localparam int unsigned REPORT_LIMIT = 10;

  // predicted parser state
  logic [1:0]  phase;
  int unsigned pos;
  logic [31:0] frame_len;
  logic [3:0]  peer_exp;
  logic [3:0]  peer_ser;

  rdf_pkg::rdf_result_t pending[$];
  int unsigned mismatches;

  function new();
    phase      = rdf_pkg::PH_HANDSHAKE;
    pos        = 0;
    frame_len  = '0;
    peer_exp   = '0;
    peer_ser   = '0;
    mismatches = 0;
  endfunction

  // advance the handshake check by one byte, returns the event code
  function logic [2:0] handshake_step(logic [7:0] b);
    logic [2:0] ev;
    ev = rdf_pkg::EV_NONE;
    if (pos == int'(rdf_pkg::HS_MAGIC)) begin
      if (b != rdf_pkg::MAGIC_BYTE) ev = rdf_pkg::EV_BAD_MAGIC;
      else pos = int'(rdf_pkg::HS_FORMAT);
    end else if (pos == int'(rdf_pkg::HS_FORMAT)) begin
      peer_exp = b[7:4];
      peer_ser = b[3:0];
      pos = int'(rdf_pkg::HS_RSV0);
    end else if (pos == int'(rdf_pkg::HS_RSV0)) begin
      if (b != 8'h00) begin
        ev = rdf_pkg::EV_RESERVED;
        pos = int'(rdf_pkg::HS_MAGIC);
      end else begin
        pos = int'(rdf_pkg::HS_RSV1);
      end
    end else begin
      if (b != 8'h00) begin
        ev = rdf_pkg::EV_RESERVED;
        pos = int'(rdf_pkg::HS_MAGIC);
      end else begin
        ev = rdf_pkg::EV_HS_OK;
        phase = rdf_pkg::PH_PREFIX;
        pos = 0;
        frame_len = '0;
      end
    end
    return ev;
  endfunction

  // predict the result of one accepted input byte
  function void note_byte(logic [7:0] b);
    rdf_pkg::rdf_result_t r;
    logic [63:0] wide;
    r = '0;
    r.event_res = rdf_pkg::EV_NONE;
    case (phase)
      rdf_pkg::PH_PREFIX: begin
        if (pos == 0) frame_len = '0;
        wide = ({32'd0, frame_len} << 8) | {56'd0, b};
        wide = wide & ((64'd1 << LEN_BITS) - 64'd1);
        frame_len = wide[31:0];
        pos++;
        if (pos >= PREFIX_BYTES) begin
          pos = 0;
          if (frame_len == 0) r.event_res = rdf_pkg::EV_EMPTY;
          else phase = rdf_pkg::PH_PAYLOAD;
        end
      end
      rdf_pkg::PH_PAYLOAD: begin
        r.event_res = rdf_pkg::EV_DATA;
        r.payload_byte = b;
        pos++;
        if (pos >= frame_len) begin
          r.frame_last = 1'b1;
          phase = rdf_pkg::PH_PREFIX;
          pos = 0;
        end
      end
      default: begin
        phase = rdf_pkg::PH_HANDSHAKE;
        r.event_res = handshake_step(b);
      end
    endcase
    r.max_len_exponent = peer_exp;
    r.serializer_code  = peer_ser;
    pending.push_back(r);
  endfunction

  // compare one result transaction with the oldest prediction
  function void check_result(rdf_pkg::rdf_result_t got);
    rdf_pkg::rdf_result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected result: ev=%0d data=%02h last=%0d exp=%0d ser=%0d",
                 got.event_res, got.payload_byte, got.frame_last,
                 got.max_len_exponent, got.serializer_code);
      return;
    end
    want = pending.pop_front();
    if (got.event_res != want.event_res || got.payload_byte != want.payload_byte ||
        got.frame_last != want.frame_last ||
        got.max_len_exponent != want.max_len_exponent ||
        got.serializer_code != want.serializer_code) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $write("mismatch: expected ev=%0d data=%02h last=%0d exp=%0d ser=%0d,",
               want.event_res, want.payload_byte, want.frame_last,
               want.max_len_exponent, want.serializer_code);
        $display(" got ev=%0d data=%02h last=%0d exp=%0d ser=%0d",
                 got.event_res, got.payload_byte, got.frame_last,
                 got.max_len_exponent, got.serializer_code);
      end
    end
  endfunction
endclass

module tb
  import rdf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_BITS = 32;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 8;          // margin after the last outstanding result
  localparam int WATCHDOG_LIMIT = 4000;     // cycles without any transaction
  localparam int RANDOM_BYTES = 450;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_event_res;
  logic [7:0] out_payload_byte;
  logic       out_frame_last;
  logic [3:0] out_max_len_exponent;
  logic [3:0] out_serializer_code;

  // idle percentages for the sender and the receiver, changed per phase
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 74;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  deframe_scoreboard sb = new();

  rawsocket_frame_deframer #(
    .LEN_BITS(LEN_BITS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_payload_byte    (out_payload_byte),
    .out_frame_last      (out_frame_last),
    .out_max_len_exponent(out_max_len_exponent),
    .out_serializer_code (out_serializer_code)
  );

  always #1 clk = ~clk;

  // receiver: ready toggles at random on the falling edge, one assignment per step
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // result monitor: every accepted result transaction goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_event_res, out_payload_byte, out_frame_last,
                       out_max_len_exponent, out_serializer_code});
  end

  // watchdog: ends the run if no transaction happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // drive one byte; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    // random sender gap before the transaction
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    // hold the byte until the handshake completes
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // one frame: big-endian length prefix then random payload bytes
  task automatic send_frame(input logic [31:0] len);
    send_byte(len[31:24]);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int unsigned k = 0; k < len; k++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // mostly short frames, some empty ones and a few that need a nonzero third prefix byte
  function automatic logic [31:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    else if (r < 88) return 32'($urandom_range(1, 16));
    else if (r < 98) return 32'($urandom_range(17, 64));
    else return 32'($urandom_range(256, 511));
  endfunction

  initial begin
    int unsigned phase_end;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed part ---
    // bad magic: zero and all-ones first bytes, the block stays on the first byte
    send_byte(8'h00);
    send_byte(8'hff);
    // nonzero first reserved byte restarts the handshake
    send_byte(MAGIC_BYTE);
    send_byte(8'h0f);
    send_byte(8'h01);
    // nonzero second reserved byte, exponent 15 and serializer 2 are kept
    send_byte(MAGIC_BYTE);
    send_byte(8'hf2);
    send_byte(8'h00);
    send_byte(8'h80);
    // good handshake: max exponent, serializer code 1
    send_byte(MAGIC_BYTE);
    send_byte(8'hf1);
    send_byte(8'h00);
    send_byte(8'h00);
    // empty frame, then a one-byte frame with an all-ones payload byte
    send_frame(32'd0);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hff);
    // two-byte frame, payload starts with a zero byte
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'ha5);

    // --- random frames, three idling phases ---
    phase_end = bytes_sent + RANDOM_BYTES / 3;
    while (bytes_sent < phase_end) send_frame(pick_length());

    // sender idles heavily, receiver rarely stalls
    tx_idle_pct = 74;
    rx_idle_pct = 10;
    phase_end = bytes_sent + RANDOM_BYTES / 3;
    while (bytes_sent < phase_end) send_frame(pick_length());

    // no idling at all, back-to-back bytes
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    phase_end = bytes_sent + RANDOM_BYTES / 3;
    while (bytes_sent < phase_end) send_frame(pick_length());
    in_valid = 1'b0;

    // drain outstanding results, the watchdog bounds this wait
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
